[hw/rtl/q2e_pkg.sv]
`default_nettype none

package q2e_pkg;

    // Operand widths (fixed by the Q2.14 input format)
    localparam int TW  = 35;  // t0..t4, Q.28 with headroom
    localparam int T2W = 30;  // clamped t2, [-2^28, 2^28]
    localparam int QW  = 29;  // square root result, [0, 2^28]
    localparam int RW  = 57;  // square root remainder, [0, 2^56]
    localparam int CW  = 37;  // CORDIC x/y datapath

    localparam logic signed [TW-1:0] T_ONE = TW'(64'sd268435456);

    typedef struct packed {
        logic signed [TW-1:0]  t0;
        logic signed [TW-1:0]  t1;
        logic signed [T2W-1:0] t2;
        logic signed [TW-1:0]  t3;
        logic signed [TW-1:0]  t4;
    } t_terms;

    // atan(2^-i), 2^31 = pi
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // table entry rounded half up to ab angle bits
    function automatic logic [33:0] atan_entry(input int i, input int ab);
        logic [33:0] s;
        s = {2'b00, ATAN_TAB[i % 32]};
        if (ab < 32) begin
            s = s + (34'd1 << (31 - ab));
        end
        return s >> (32 - ab);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/quaternion_to_euler_unit.sv]
`default_nettype none

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+------------------------------------------
// request   | in        | i_valid / o_stall  | i_quat_w, i_quat_x, i_quat_y, i_quat_z
// result    | out       | o_valid / i_stall  | o_pitch_angle, o_roll_angle, o_yaw_angle
//
// Throughput: one request per cycle while o_stall is low. An accepted request
// passes through these registered steps in order to o_valid (products, terms,
// t2 square, radicand, 29 root cells, pre-rotation, CORDIC cells, rounding, output register).
// Synchronous active-low reset clears only the valid bits.
// A stalled output pushes one more result into the skid register; while the
// skid register is full the whole pipeline holds and o_stall is high.

module quaternion_to_euler_unit import q2e_pkg::*; #(
    parameter int CORDIC_STAGES = 16,
    parameter int ANGLE_BITS    = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_pitch_angle,
    output logic signed [15:0]      o_roll_angle,
    output logic signed [15:0]      o_yaw_angle
);

    localparam int ZW  = ANGLE_BITS + 2;
    localparam int N   = CORDIC_STAGES;
    localparam int LV  = 4 + QW + 1 + N + 1;   // stages before the output register

    logic r_skid_v;
    logic en;
    assign en = !r_skid_v;

    // valid shift chain for the pipeline
    logic [LV-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LV-2:0], i_valid};
        end
    end

    // stage 1: products, Q4.28
    logic signed [31:0] r_yy, r_zz, r_xx, r_xy, r_wz, r_wy, r_xz, r_yz, r_wx;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yy <= i_quat_y * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
            r_xx <= i_quat_x * i_quat_x;
            r_xy <= i_quat_x * i_quat_y;
            r_wz <= i_quat_w * i_quat_z;
            r_wy <= i_quat_w * i_quat_y;
            r_xz <= i_quat_x * i_quat_z;
            r_yz <= i_quat_y * i_quat_z;
            r_wx <= i_quat_w * i_quat_x;
        end
    end

    // stage 2: terms, t2 clamped to [-1, 1]
    logic signed [TW-1:0] t2_raw;
    t_terms               n_terms;
    t_terms               r_terms2, r_terms3, r_terms4;

    always_comb begin
        n_terms.t0 = T_ONE - ((TW'(r_yy) + TW'(r_zz)) <<< 1);
        n_terms.t1 = (TW'(r_xy) + TW'(r_wz)) <<< 1;
        n_terms.t3 = (TW'(r_yz) + TW'(r_wx)) <<< 1;
        n_terms.t4 = T_ONE - ((TW'(r_xx) + TW'(r_yy)) <<< 1);
        t2_raw     = (TW'(r_wy) - TW'(r_xz)) <<< 1;
        if (t2_raw > T_ONE) begin
            n_terms.t2 = T2W'(T_ONE);
        end else if (t2_raw < -T_ONE) begin
            n_terms.t2 = T2W'(-T_ONE);
        end else begin
            n_terms.t2 = T2W'(t2_raw);
        end
    end

    // stage 3: t2 squared; stage 4: radicand 2^56 - t2^2
    logic [T2W-1:0] t2_abs;
    logic [RW-1:0]  r_sq, r_rad;

    assign t2_abs = r_terms2.t2[T2W-1] ? T2W'(-r_terms2.t2) : T2W'(r_terms2.t2);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_terms2 <= n_terms;
            r_sq     <= RW'(t2_abs[QW-1:0] * t2_abs[QW-1:0]);
            r_terms3 <= r_terms2;
            r_rad    <= (RW'(1) << (RW - 1)) - r_sq;
            r_terms4 <= r_terms3;
        end
    end

    // root cells, one result bit each
    logic [RW-1:0] s_rem   [QW+1];
    logic [QW-1:0] s_q     [QW+1];
    t_terms        s_terms [QW+1];

    assign s_rem[0]   = r_rad;
    assign s_q[0]     = '0;
    assign s_terms[0] = r_terms4;

    for (genvar j = 0; j < QW; j++) begin : g_sqrt
        q2e_sqrt_cell #(.K(QW - 1 - j)) u_cell (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_rem   (s_rem[j]),
            .i_q     (s_q[j]),
            .i_terms (s_terms[j]),
            .o_rem   (s_rem[j+1]),
            .o_q     (s_q[j+1]),
            .o_terms (s_terms[j+1])
        );
    end

    // three CORDIC lanes: 0 pitch, 1 roll, 2 yaw
    logic signed [CW-1:0] ly [3];
    logic signed [CW-1:0] lx [3];
    logic signed [CW-1:0] cx [3][N+1];
    logic signed [CW-1:0] cy [3][N+1];
    logic signed [ZW-1:0] cz [3][N+1];
    logic                 cb [3][N+1];
    logic signed [17:0]   r16 [3];

    assign ly[0] = CW'(s_terms[QW].t2);
    assign lx[0] = signed'(CW'(s_q[QW]));
    assign ly[1] = CW'(s_terms[QW].t3);
    assign lx[1] = CW'(s_terms[QW].t4);
    assign ly[2] = CW'(s_terms[QW].t1);
    assign lx[2] = CW'(s_terms[QW].t0);

    for (genvar l = 0; l < 3; l++) begin : g_lane
        q2e_cordic_pre #(.ANGLE_BITS(ANGLE_BITS)) u_pre (
            .i_clk (i_clk),
            .i_en  (en),
            .i_y   (ly[l]),
            .i_x   (lx[l]),
            .o_x   (cx[l][0]),
            .o_y   (cy[l][0]),
            .o_z   (cz[l][0]),
            .o_byp (cb[l][0])
        );
        for (genvar s = 0; s < N; s++) begin : g_rot
            q2e_cordic_cell #(.STAGE(s), .ANGLE_BITS(ANGLE_BITS)) u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_x   (cx[l][s]),
                .i_y   (cy[l][s]),
                .i_z   (cz[l][s]),
                .i_byp (cb[l][s]),
                .o_x   (cx[l][s+1]),
                .o_y   (cy[l][s+1]),
                .o_z   (cz[l][s+1]),
                .o_byp (cb[l][s+1])
            );
        end
        // scale the accumulator to a 16-bit angle, rounding half up when ANGLE_BITS > 16
        if (ANGLE_BITS > 16) begin : g_rnd
            localparam int SH = ANGLE_BITS - 16;
            logic signed [ZW-1:0] rnd;
            assign rnd    = cz[l][N] + (ZW'(1) << (SH - 1));
            assign r16[l] = 18'(rnd >>> SH);
        end else if (ANGLE_BITS == 16) begin : g_eq
            assign r16[l] = 18'(cz[l][N]);
        end else begin : g_shl
            assign r16[l] = {cz[l][N], (16 - ANGLE_BITS)'(0)};
        end
    end

    // final stage: pitch saturated to a quarter turn
    logic signed [15:0] r_fin_p, r_fin_r, r_fin_y;
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r16[0] > 18'sd16384) begin
                r_fin_p <= 16'sd16384;
            end else if (r16[0] < -18'sd16384) begin
                r_fin_p <= -16'sd16384;
            end else begin
                r_fin_p <= r16[0][15:0];
            end
            r_fin_r <= r16[1][15:0];
            r_fin_y <= r16[2][15:0];
        end
    end

    // output register plus skid register
    logic               tail_v, out_take;
    logic               r_out_v;
    logic signed [15:0] r_out_p, r_out_r, r_out_y;
    logic signed [15:0] r_skid_p, r_skid_r, r_skid_y;

    assign tail_v   = r_vld[LV-1];
    assign out_take = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (out_take || !r_out_v) begin
                    r_out_p  <= r_skid_p;
                    r_out_r  <= r_skid_r;
                    r_out_y  <= r_skid_y;
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end
            end else if (tail_v) begin
                if (out_take || !r_out_v) begin
                    r_out_p <= r_fin_p;
                    r_out_r <= r_fin_r;
                    r_out_y <= r_fin_y;
                    r_out_v <= 1'b1;
                end else begin
                    r_skid_p <= r_fin_p;
                    r_skid_r <= r_fin_r;
                    r_skid_y <= r_fin_y;
                    r_skid_v <= 1'b1;
                end
            end else if (out_take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_stall       = r_skid_v;
    assign o_valid       = r_out_v;
    assign o_pitch_angle = r_out_p;
    assign o_roll_angle  = r_out_r;
    assign o_yaw_angle   = r_out_y;

    // skid register only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register full with empty output register");

    // skid register fills only when the output was held
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skid_v ##1 r_skid_v) |-> $past(r_out_v && i_stall))
        else $error("skid register filled without output stall");

    // pitch never leaves a quarter turn
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_angle <= 16'sd16384 && o_pitch_angle >= -16'sd16384))
        else $error("pitch out of range");

endmodule

`default_nettype wire

[hw/rtl/q2e_sqrt_cell.sv]
`default_nettype none

// One result bit of the integer square root per cell.
module q2e_sqrt_cell import q2e_pkg::*; #(
    parameter int K = 28
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [RW-1:0] i_rem,
    input  wire logic [QW-1:0] i_q,
    input  wire t_terms        i_terms,
    output logic [RW-1:0]      o_rem,
    output logic [QW-1:0]      o_q,
    output t_terms             o_terms
);

    logic [RW+2:0] cand;
    logic          take;
    logic [RW-1:0] r_rem;
    logic [QW-1:0] r_q;
    t_terms        r_terms;

    assign cand = ({(RW + 3 - QW)'(0), i_q} << (K + 1)) + ((RW + 3)'(1) << (2 * K));
    assign take = {3'b000, i_rem} >= cand;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem   <= take ? RW'({3'b000, i_rem} - cand) : i_rem;
            r_q     <= take ? (i_q | (QW'(1) << K)) : i_q;
            r_terms <= i_terms;
        end
    end

    assign o_rem   = r_rem;
    assign o_q     = r_q;
    assign o_terms = r_terms;

endmodule

`default_nettype wire

[hw/rtl/q2e_cordic_pre.sv]
`default_nettype none

// Quadrant pre-rotation into the right half plane; x == 0 is resolved here.
module q2e_cordic_pre import q2e_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic signed [CW-1:0]   i_y,
    input  wire logic signed [CW-1:0]   i_x,
    output logic signed [CW-1:0]        o_x,
    output logic signed [CW-1:0]        o_y,
    output logic signed [ANGLE_BITS+1:0] o_z,
    output logic                        o_byp
);

    localparam int ZW = ANGLE_BITS + 2;
    localparam logic signed [ZW-1:0] QUARTER = ZW'(1) << (ANGLE_BITS - 2);

    logic signed [CW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;
    logic                 n_byp;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic                 r_byp;

    always_comb begin
        n_x   = i_x;
        n_y   = i_y;
        n_z   = '0;
        n_byp = 1'b0;
        if (i_x == '0) begin
            n_byp = 1'b1;
            if (i_y > 0) begin
                n_z = QUARTER;
            end else if (i_y < 0) begin
                n_z = -QUARTER;
            end
        end else if (i_x < 0) begin
            if (i_y >= 0) begin
                n_z = QUARTER;
                n_x = i_y;
                n_y = -i_x;
            end else begin
                n_z = -QUARTER;
                n_x = -i_y;
                n_y = i_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_byp <= n_byp;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_byp = r_byp;

endmodule

`default_nettype wire

[hw/rtl/q2e_cordic_cell.sv]
`default_nettype none

// One vectoring micro-rotation.
module q2e_cordic_cell import q2e_pkg::*; #(
    parameter int STAGE      = 0,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [CW-1:0]    i_x,
    input  wire logic signed [CW-1:0]    i_y,
    input  wire logic signed [ANGLE_BITS+1:0] i_z,
    input  wire logic                    i_byp,
    output logic signed [CW-1:0]         o_x,
    output logic signed [CW-1:0]         o_y,
    output logic signed [ANGLE_BITS+1:0] o_z,
    output logic                         o_byp
);

    localparam int ZW = ANGLE_BITS + 2;
    localparam logic [33:0] A_FULL = atan_entry(STAGE, ANGLE_BITS);
    localparam logic signed [ZW-1:0] A = A_FULL[ZW-1:0];

    logic signed [CW-1:0] dx, dy;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic                 r_byp;

    assign dx = i_y >>> STAGE;
    assign dy = i_x >>> STAGE;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_byp <= i_byp;
            if (i_byp) begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= i_z;
            end else if (!i_y[CW-1]) begin
                r_x <= i_x + dx;
                r_y <= i_y - dy;
                r_z <= i_z + A;
            end else begin
                r_x <= i_x - dx;
                r_y <= i_y + dy;
                r_z <= i_z - A;
            end
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_byp = r_byp;

endmodule

`default_nettype wire
